// ----- hdl/lz10_pkg.sv -----
// LZ10 decompressor package: field widths, status codes and stream constants.
// No dependencies; used by the interfaces, lz10_window and the top level.
package lz10_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LenW    = 24;
  localparam int unsigned DistW   = 13;
  localparam int unsigned CountW  = 5;
  localparam int unsigned HdrCntW = 4;
  localparam int unsigned FlagCntW = 4;

  localparam logic [StatusW-1:0] StData   = 2'd0;
  localparam logic [StatusW-1:0] StMethod = 2'd1;
  localparam logic [StatusW-1:0] StRange  = 2'd2;

  localparam logic [ByteW-1:0]   LzMethod   = 8'h10;
  localparam int unsigned        LenShift   = 12;
  localparam logic [HdrCntW-1:0] HdrMethod  = 4'd4;
  localparam logic [HdrCntW-1:0] HdrLen0    = 4'd5;
  localparam logic [HdrCntW-1:0] HdrLen1    = 4'd6;
  localparam logic [HdrCntW-1:0] HdrLen2    = 4'd7;
  localparam logic [FlagCntW-1:0] FlagsPerGroup = 4'd8;
  localparam logic [CountW-1:0]  MinMatch   = 5'd3;

endpackage

// ----- hdl/lz10_in_if.sv -----
// Input channel: one compressed byte per item, plus the stream start mark.
// Depends on lz10_pkg.
interface lz10_in_if;
  logic                        valid;
  logic                        ready;
  logic [lz10_pkg::ByteW-1:0]  in_byte;
  logic                        stream_start;

  modport source (output valid, output in_byte, output stream_start, input ready);
  modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface

// ----- hdl/lz10_out_if.sv -----
// Output channel: one decompressed byte or error status per item.
// Depends on lz10_pkg.
interface lz10_out_if;
  logic                          valid;
  logic                          ready;
  logic [lz10_pkg::ByteW-1:0]    out_byte;
  logic                          final_byte;
  logic [lz10_pkg::StatusW-1:0]  status;

  modport source (output valid, output out_byte, output final_byte, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input final_byte, input status,
                  output ready);
endinterface

// ----- hdl/lz10_window.sv -----
// History window: one write port, one registered read port, with forwarding
// of a write to the same entry in the cycle the read is issued. Uses lz10_pkg.
module lz10_window #(
  parameter int unsigned WINDOW_DEPTH = 4096,
  localparam int unsigned AW = $clog2(WINDOW_DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [lz10_pkg::ByteW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [lz10_pkg::ByteW-1:0] rdata_o
);

  logic [lz10_pkg::ByteW-1:0] mem_q [WINDOW_DEPTH];
  logic [lz10_pkg::ByteW-1:0] rdata_q;
  logic [lz10_pkg::ByteW-1:0] fwd_data_q;
  logic                       fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q    <= mem_q[raddr_i];
      fwd_data_q <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (re_i) begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

// ----- hdl/lz10_stream_decompressor.sv -----
// LZ10 stream decompressor top level: header/flag/token decoder and copy engine.
// Depends on lz10_pkg, lz10_in_if, lz10_out_if and lz10_window.
//
//   channel | dir | item
//   in_i    | in  | in_byte[7:0], stream_start
//   out_o   | out | out_byte[7:0], final_byte, status[1:0]
//
// A header, flag or literal byte is decoded in the cycle it is accepted. A reference's
// low byte starts the copy, which emits one byte per cycle (3 to 18) with one window
// read and one write each, unless the output stalls; input is held off during the copy.
// Reset clears all control state; the window is not cleared and never read
// before it is written in the current stream. A stalled output holds the copy.
module lz10_stream_decompressor #(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lz10_in_if.sink     in_i,
  lz10_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_FLAGS, PH_TOKEN, PH_REF_LOW, PH_COPY, PH_DONE
  } phase_e;

  phase_e                          phase_q, phase_d, ph_e;
  logic [AW-1:0]                   wr_q, wr_d, wr_next;
  logic [AW-1:0]                   src_q, src_d, src_next, src_init;
  logic [lz10_pkg::HdrCntW-1:0]    hc_q, hc_d, hc_e;
  logic [lz10_pkg::LenW-1:0]       rem_q, rem_d, rem_e, rem_hdr;
  logic [lz10_pkg::LenW-1:0]       prod_q, prod_d, prod_e;
  logic [lz10_pkg::ByteW-1:0]      fb_q, fb_d, fb_e;
  logic [lz10_pkg::FlagCntW-1:0]   fl_q, fl_d, fl_e;
  logic [lz10_pkg::ByteW-1:0]      rh_q, rh_d, rh_e;
  logic [lz10_pkg::CountW-1:0]     cnt_q, cnt_d;

  logic                            out_valid_q, out_valid_d;
  logic [lz10_pkg::ByteW-1:0]      out_byte_q, out_byte_d;
  logic                            out_final_q, out_final_d;
  logic [lz10_pkg::StatusW-1:0]    out_status_q, out_status_d;

  logic                            in_acc, start, out_free;
  logic [lz10_pkg::ByteW-1:0]      b;
  logic [lz10_pkg::DistW-1:0]      ref_dist;
  logic [AW:0]                     wr_ext, dist_ext;

  logic                            data_emit, err_emit, token_end, last;
  logic [lz10_pkg::ByteW-1:0]      emit_byte;
  logic [lz10_pkg::StatusW-1:0]    err_status;
  logic                            win_re;
  logic [AW-1:0]                   win_raddr;
  logic [lz10_pkg::ByteW-1:0]      win_rdata;

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (phase_q != PH_COPY) && out_free;
  assign in_acc      = in_i.valid && in_i.ready;
  assign start       = in_acc && in_i.stream_start;
  assign b           = in_i.in_byte;

  assign ph_e   = start ? PH_HEADER : phase_q;
  assign hc_e   = start ? '0 : hc_q;
  assign rem_e  = start ? '0 : rem_q;
  assign prod_e = start ? '0 : prod_q;
  assign fb_e   = start ? '0 : fb_q;
  assign fl_e   = start ? '0 : fl_q;
  assign rh_e   = start ? '0 : rh_q;

  assign wr_next  = (wr_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wr_q + AW'(1);
  assign src_next = (src_q == AW'(WINDOW_DEPTH - 1)) ? '0 : src_q + AW'(1);

  assign ref_dist = {1'b0, rh_e[3:0], b} + lz10_pkg::DistW'(1);
  assign wr_ext   = {1'b0, wr_q};
  assign dist_ext = (AW+1)'(ref_dist);
  assign src_init = (wr_ext >= dist_ext) ? AW'(wr_ext - dist_ext)
                                         : AW'(wr_ext + (AW+1)'(WINDOW_DEPTH) - dist_ext);

  always_comb begin
    rem_hdr = rem_e;
    unique case (hc_e)
      lz10_pkg::HdrLen0: rem_hdr[7:0]   = rem_e[7:0]   | b;
      lz10_pkg::HdrLen1: rem_hdr[15:8]  = rem_e[15:8]  | b;
      lz10_pkg::HdrLen2: rem_hdr[23:16] = rem_e[23:16] | b;
      default: rem_hdr = rem_e;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    wr_d       = wr_q;
    src_d      = src_q;
    hc_d       = hc_q;
    rem_d      = rem_q;
    prod_d     = prod_q;
    fb_d       = fb_q;
    fl_d       = fl_q;
    rh_d       = rh_q;
    cnt_d      = cnt_q;
    data_emit  = 1'b0;
    err_emit   = 1'b0;
    err_status = lz10_pkg::StData;
    token_end  = 1'b0;
    emit_byte  = b;
    win_re     = 1'b0;
    win_raddr  = src_init;

    if (in_acc) begin
      phase_d = ph_e;
      hc_d    = hc_e;
      rem_d   = rem_e;
      prod_d  = prod_e;
      fb_d    = fb_e;
      fl_d    = fl_e;
      rh_d    = rh_e;
      unique case (ph_e)
        PH_HEADER: begin
          if (hc_e == lz10_pkg::HdrMethod && b != lz10_pkg::LzMethod) begin
            err_emit   = 1'b1;
            err_status = lz10_pkg::StMethod;
            phase_d    = PH_IDLE;
          end else begin
            rem_d = rem_hdr;
            hc_d  = hc_e + lz10_pkg::HdrCntW'(1);
            if (hc_e == lz10_pkg::HdrLen2) begin
              phase_d = (rem_hdr == '0) ? PH_DONE : PH_FLAGS;
            end
          end
        end
        PH_FLAGS: begin
          fb_d    = b;
          fl_d    = lz10_pkg::FlagsPerGroup;
          phase_d = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (fb_e[7]) begin
            rh_d    = b;
            phase_d = PH_REF_LOW;
          end else begin
            data_emit = 1'b1;
            emit_byte = b;
          end
        end
        PH_REF_LOW: begin
          if (lz10_pkg::LenW'(ref_dist) > prod_e) begin
            err_emit   = 1'b1;
            err_status = lz10_pkg::StRange;
            phase_d    = PH_IDLE;
          end else begin
            cnt_d     = lz10_pkg::MinMatch + lz10_pkg::CountW'(rh_e >> (lz10_pkg::LenShift - 8));
            src_d     = src_init;
            win_re    = 1'b1;
            win_raddr = src_init;
            phase_d   = PH_COPY;
          end
        end
        default: ;
      endcase
    end else if (phase_q == PH_COPY && out_free) begin
      data_emit = 1'b1;
      emit_byte = win_rdata;
    end

    last = data_emit && (rem_e == lz10_pkg::LenW'(1));
    if (data_emit) begin
      wr_d   = wr_next;
      prod_d = prod_e + lz10_pkg::LenW'(1);
      rem_d  = rem_e - lz10_pkg::LenW'(1);
      if (phase_q == PH_COPY) begin
        if (last || cnt_q == lz10_pkg::CountW'(1)) begin
          token_end = 1'b1;
        end else begin
          cnt_d     = cnt_q - lz10_pkg::CountW'(1);
          win_re    = 1'b1;
          win_raddr = src_next;
          src_d     = src_next;
        end
      end else begin
        token_end = 1'b1;
      end
    end

    if (token_end) begin
      fb_d = fb_e << 1;
      fl_d = fl_e - lz10_pkg::FlagCntW'(1);
      priority if (last) begin
        phase_d = PH_DONE;
      end else if (fl_e == lz10_pkg::FlagCntW'(1)) begin
        phase_d = PH_FLAGS;
      end else begin
        phase_d = PH_TOKEN;
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_final_d  = out_final_q;
    out_status_d = out_status_q;
    priority if (data_emit) begin
      out_valid_d  = 1'b1;
      out_byte_d   = emit_byte;
      out_final_d  = last;
      out_status_d = lz10_pkg::StData;
    end else if (err_emit) begin
      out_valid_d  = 1'b1;
      out_byte_d   = '0;
      out_final_d  = 1'b0;
      out_status_d = err_status;
    end else if (out_o.ready) begin
      out_valid_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      wr_q        <= '0;
      src_q       <= '0;
      hc_q        <= '0;
      rem_q       <= '0;
      prod_q      <= '0;
      fb_q        <= '0;
      fl_q        <= '0;
      rh_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      wr_q        <= wr_d;
      src_q       <= src_d;
      hc_q        <= hc_d;
      rem_q       <= rem_d;
      prod_q      <= prod_d;
      fb_q        <= fb_d;
      fl_q        <= fl_d;
      rh_q        <= rh_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q   <= out_byte_d;
    out_final_q  <= out_final_d;
    out_status_q <= out_status_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.final_byte = out_final_q;
  assign out_o.status     = out_status_q;

  lz10_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (data_emit),
    .waddr_i (wr_q),
    .wdata_i (emit_byte),
    .re_i    (win_re),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

endmodule

// ----- bench/lz10_stream_decompressor_tb.sv -----
// Testbench for lz10_stream_decompressor: streams LZ10 data in through lz10_in_if
// and checks every output item (byte, final, status) against a predictor of the decoder.
// Depends on lz10_pkg, lz10_in_if, lz10_out_if and the RTL under hdl.
module lz10_stream_decompressor_tb;

  localparam int unsigned WinDepth    = 4096;
  localparam int unsigned HdrBytes    = 8;
  localparam int unsigned MaxCopy     = 18;
  localparam int unsigned RandItems   = 40;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned NoCut       = 1000000;

  typedef enum logic [2:0] {PhIdle, PhHeader, PhFlags, PhToken, PhRefLow, PhDone} phase_e;

  typedef struct packed {
    logic [lz10_pkg::ByteW-1:0]   data;
    logic                         last;
    logic [lz10_pkg::StatusW-1:0] status;
  } lz_out_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  lz10_in_if  in_if ();
  lz10_out_if out_if ();

  lz10_stream_decompressor i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // decoder state mirror
  logic [lz10_pkg::ByteW-1:0]    window_mem [WinDepth];
  logic [11:0]                   wr_idx     = '0;
  logic [lz10_pkg::HdrCntW-1:0]  hdr_cnt    = '0;
  logic [lz10_pkg::LenW-1:0]     remaining  = '0;
  logic [lz10_pkg::LenW-1:0]     produced   = '0;
  logic [lz10_pkg::ByteW-1:0]    flags      = '0;
  logic [lz10_pkg::FlagCntW-1:0] flags_left = '0;
  logic [lz10_pkg::ByteW-1:0]    ref_hi     = '0;
  phase_e                        phase      = PhIdle;

  lz_out_t     expected_out [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_count  = 0;
  int unsigned burst_left  = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic void queue_result(input lz_out_t r);
    expected_out = {expected_out, r};
  endfunction

  function automatic logic emit_byte(input logic [lz10_pkg::ByteW-1:0] b);
    window_mem[wr_idx] = b;
    wr_idx++;
    produced++;
    remaining--;
    queue_result(lz_out_t'{data: b, last: (remaining == '0), status: lz10_pkg::StData});
    return remaining == '0;
  endfunction

  function automatic void end_token(input logic last);
    flags = flags << 1;
    if (flags_left != '0) flags_left--;
    if (last) phase = PhDone;
    else if (flags_left == '0) phase = PhFlags;
    else phase = PhToken;
  endfunction

  function automatic void decode_byte(input logic [lz10_pkg::ByteW-1:0] b, input logic start);
    logic [15:0]                 info;
    logic [lz10_pkg::CountW-1:0] count;
    logic [lz10_pkg::DistW-1:0]  ref_dist;
    logic                        last;
    int unsigned                 p;
    if (start) begin
      hdr_cnt    = '0;
      remaining  = '0;
      produced   = '0;
      flags      = '0;
      flags_left = '0;
      ref_hi     = '0;
      phase      = PhHeader;
    end
    case (phase)
      PhHeader: begin
        if (hdr_cnt == lz10_pkg::HdrMethod && b != lz10_pkg::LzMethod) begin
          queue_result(lz_out_t'{data: '0, last: 1'b0, status: lz10_pkg::StMethod});
          phase = PhIdle;
        end else begin
          if (hdr_cnt == lz10_pkg::HdrLen0) remaining[7:0] = b;
          if (hdr_cnt == lz10_pkg::HdrLen1) remaining[15:8] = b;
          if (hdr_cnt == lz10_pkg::HdrLen2) remaining[23:16] = b;
          hdr_cnt++;
          if (hdr_cnt == lz10_pkg::HdrCntW'(HdrBytes))
            phase = (remaining == '0) ? PhDone : PhFlags;
        end
      end
      PhFlags: begin
        flags      = b;
        flags_left = lz10_pkg::FlagsPerGroup;
        phase      = PhToken;
      end
      PhToken: begin
        if (flags[lz10_pkg::ByteW-1]) begin
          ref_hi = b;
          phase  = PhRefLow;
        end else begin
          end_token(emit_byte(b));
        end
      end
      PhRefLow: begin
        info     = {ref_hi, b};
        count    = lz10_pkg::MinMatch + lz10_pkg::CountW'(info >> lz10_pkg::LenShift);
        ref_dist = lz10_pkg::DistW'(info[11:0]) + lz10_pkg::DistW'(1);
        if (lz10_pkg::LenW'(ref_dist) > produced) begin
          queue_result(lz_out_t'{data: '0, last: 1'b0, status: lz10_pkg::StRange});
          phase = PhIdle;
        end else begin
          last = 1'b0;
          for (p = 0; p < count && !last; p++)
            last = emit_byte(window_mem[wr_idx - ref_dist[11:0]]);
          end_token(last);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end else if (rst_ni) begin
      lz_out_t want;
      if (in_if.valid && in_if.ready) decode_byte(in_if.in_byte, in_if.stream_start);
      if (out_if.valid && out_if.ready) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("unexpected item: byte %h final %b status %0d",
                                    out_if.out_byte, out_if.final_byte, out_if.status));
        end else begin
          want = expected_out.pop_front();
          if (out_if.out_byte !== want.data)
            report_mismatch($sformatf("out_byte %h, expected %h", out_if.out_byte, want.data));
          if (out_if.final_byte !== want.last)
            report_mismatch($sformatf("final_byte %b, expected %b", out_if.final_byte,
                                      want.last));
          if (out_if.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_if.status, want.status));
        end
      end
    end
  end

  // receiver backpressure
  initial begin
    int unsigned mode;
    int unsigned left;
    int unsigned tick;
    out_if.ready <= 1'b0;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      tick++;
      case (mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 3) != 0);
        2:       out_if.ready <= ((tick % 5) < 3);
        default: out_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic send_item(input logic [lz10_pkg::ByteW-1:0] b, input logic start);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid        <= 1'b1;
    in_if.in_byte      <= b;
    in_if.stream_start <= start;
    do @(posedge clk_i); while (!in_if.ready);
    sent_count++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_out.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_header(input logic [lz10_pkg::LenW-1:0] len,
                             input logic [lz10_pkg::ByteW-1:0] method);
    send_item(lz10_pkg::ByteW'($urandom), 1'b1);
    repeat (3) send_item(lz10_pkg::ByteW'($urandom), 1'b0);
    send_item(method, 1'b0);
    if (method == lz10_pkg::LzMethod) begin
      send_item(len[7:0], 1'b0);
      send_item(len[15:8], 1'b0);
      send_item(len[23:16], 1'b0);
    end
  endtask

  // random-content stream with a valid header; err_pct gives the share of bad distances,
  // cut stops it after that many tokens, long_refs packs it with maximal copies
  task automatic send_stream(input logic [lz10_pkg::LenW-1:0] len, input int unsigned err_pct,
                             input int unsigned cut, input logic long_refs);
    int unsigned made;
    int unsigned tokens;
    int unsigned cnt;
    int unsigned ref_dist;
    int unsigned lim;
    int unsigned i;
    logic [11:0] code;
    logic [lz10_pkg::ByteW-1:0] fl;
    logic first;
    send_header(len, lz10_pkg::LzMethod);
    made   = 0;
    tokens = 0;
    first  = 1'b1;
    while (made < len && tokens < cut) begin
      fl = long_refs ? 8'hFF : lz10_pkg::ByteW'($urandom);
      if (first && err_pct == 0) fl[lz10_pkg::ByteW-1] = 1'b0;
      first = 1'b0;
      send_item(fl, 1'b0);
      for (i = 0; i < lz10_pkg::ByteW && made < len && tokens < cut; i++) begin
        tokens++;
        if (fl[lz10_pkg::ByteW-1-i]) begin
          lim = (made < WinDepth) ? made : WinDepth;
          cnt = long_refs ? MaxCopy : $urandom_range(int'(lz10_pkg::MinMatch), MaxCopy);
          if (made < WinDepth && (made == 0 || $urandom_range(0, 99) < err_pct))
            ref_dist = $urandom_range(made + 1, WinDepth);
          else if (long_refs)
            ref_dist = (made >= WinDepth) ? WinDepth : $urandom_range(1, made);
          else if ($urandom_range(0, 1) != 0)
            ref_dist = $urandom_range(1, (lim < 8) ? lim : 8);
          else
            ref_dist = $urandom_range(1, lim);
          code = 12'(ref_dist - 1);
          send_item({4'(cnt - int'(lz10_pkg::MinMatch)), code[11:8]}, 1'b0);
          send_item(code[7:0], 1'b0);
          if (ref_dist > made) return;
          made += cnt;
        end else begin
          send_item(lz10_pkg::ByteW'($urandom), 1'b0);
          made++;
        end
      end
    end
  endtask

  task automatic test_literals();
    send_header(24'd4, lz10_pkg::LzMethod);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h5A, 1'b0);
    send_item(8'hA5, 1'b0);
    wait_drained();
  endtask

  task automatic test_references();
    // longest copy cut short by the declared length, then an ignored byte
    send_header(24'd6, lz10_pkg::LzMethod);
    send_item(8'h40, 1'b0);
    send_item(8'h3C, 1'b0);
    send_item(8'hF0, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hC3, 1'b0);
    // short copy, then a reference reaching before the stream start
    send_header(24'd40, lz10_pkg::LzMethod);
    send_item(8'h30, 1'b0);
    send_item(8'h11, 1'b0);
    send_item(8'h22, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h0F, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h99, 1'b0);
    wait_drained();
  endtask

  task automatic test_bad_method();
    send_header('0, 8'h11);
    send_item(8'h10, 1'b0);
    send_header('0, 8'hEF);
    send_item(8'hFF, 1'b0);
    wait_drained();
  endtask

  task automatic test_restart();
    send_header(24'hFFFFFF, lz10_pkg::LzMethod);
    send_item(8'h00, 1'b0);
    send_item(8'h81, 1'b0);
    send_item(8'h12, 1'b1);
    send_item(8'h34, 1'b0);
    send_header('0, lz10_pkg::LzMethod);
    send_item(8'h00, 1'b0);
    wait_drained();
  endtask

  task automatic test_long_copies();
    send_stream(24'd300, 0, NoCut, 1'b1);
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned base;
    int unsigned kind;
    int unsigned r;
    logic [lz10_pkg::LenW-1:0] len;
    logic [lz10_pkg::ByteW-1:0] method;
    base = sent_count;
    while (sent_count - base < RandItems) begin
      kind = $urandom_range(0, 9);
      r    = $urandom_range(0, 15);
      len  = (r == 0) ? '0 : (r < 12) ? lz10_pkg::LenW'($urandom_range(1, 24)) :
                                        lz10_pkg::LenW'($urandom_range(25, 300));
      case (kind)
        0, 1, 2, 3, 4, 5: send_stream(len, 0, NoCut, 1'b0);
        6: send_stream(len, 30, NoCut, 1'b0);
        7: begin
          method = lz10_pkg::ByteW'($urandom);
          if (method == lz10_pkg::LzMethod) method = ~method;
          send_header('0, method);
        end
        8: send_stream(lz10_pkg::LenW'($urandom), 0, $urandom_range(0, 12), 1'b0);
        default: repeat ($urandom_range(1, 4)) send_item(lz10_pkg::ByteW'($urandom), 1'b0);
      endcase
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    in_if.valid        <= 1'b0;
    in_if.in_byte      <= '0;
    in_if.stream_start <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_literals();
    test_references();
    test_bad_method();
    test_restart();
    test_long_copies();
    test_random();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/lz10_pkg.sv
hdl/lz10_in_if.sv
hdl/lz10_out_if.sv
hdl/lz10_window.sv
hdl/lz10_stream_decompressor.sv
bench/lz10_stream_decompressor_tb.sv
